// ===== design/mtk_pkg.sv =====
// Package for the multi-tap keypad text entry block.
// Holds widths, register indexes, codes and the keypad symbol functions.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package mtk_pkg;

    localparam int KEY_W      = 4;
    localparam int CHAR_W     = 7;
    localparam int TAP_W      = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMIT_DELAY  = 8'd1;

    localparam logic [CFG_DATA_W-1:0] CYCLE_TIMEOUT_RESET = 16'd600;
    localparam logic [CFG_DATA_W-1:0] COMMIT_DELAY_RESET  = 16'd600;

    // Operation codes on the input channel.
    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Key codes with a meaning of their own.
    localparam logic [KEY_W-1:0] KEY_0    = 4'd0;
    localparam logic [KEY_W-1:0] KEY_1    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_2    = 4'd2;
    localparam logic [KEY_W-1:0] KEY_3    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_4    = 4'd4;
    localparam logic [KEY_W-1:0] KEY_5    = 4'd5;
    localparam logic [KEY_W-1:0] KEY_6    = 4'd6;
    localparam logic [KEY_W-1:0] KEY_7    = 4'd7;
    localparam logic [KEY_W-1:0] KEY_8    = 4'd8;
    localparam logic [KEY_W-1:0] KEY_9    = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR = 4'd15;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd13;

    localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_ONE      = 7'h31;
    localparam logic [CHAR_W-1:0] ASCII_STAR     = 7'h2A;
    localparam logic [CHAR_W-1:0] ASCII_HASH     = 7'h23;
    localparam logic [CHAR_W-1:0] ASCII_QUESTION = 7'h3F;

    localparam logic [TAP_W-1:0] TAPS_SHORT = 3'd4;
    localparam logic [TAP_W-1:0] TAPS_LONG  = 3'd5;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic [TAP_W-1:0]  tap_index;
    } press_t;

    function automatic logic is_tap_key(input logic [KEY_W-1:0] key);
        return (key >= KEY_2) && (key <= KEY_9);
    endfunction

    function automatic logic [TAP_W-1:0] tap_count(input logic [KEY_W-1:0] key);
        return ((key == KEY_7) || (key == KEY_9)) ? TAPS_LONG : TAPS_SHORT;
    endfunction

    // First letter printed on a digit key 2 to 9.
    function automatic logic [CHAR_W-1:0] first_letter(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] letter;
        case (key)
            KEY_2:   letter = 7'h41;
            KEY_3:   letter = 7'h44;
            KEY_4:   letter = 7'h47;
            KEY_5:   letter = 7'h4A;
            KEY_6:   letter = 7'h4D;
            KEY_7:   letter = 7'h50;
            KEY_8:   letter = 7'h54;
            KEY_9:   letter = 7'h57;
            default: letter = ASCII_QUESTION;
        endcase
        return letter;
    endfunction

    // Position zero is the digit itself, then the letters in order.
    function automatic logic [CHAR_W-1:0] tap_symbol(input logic [KEY_W-1:0] key,
                                                     input logic [TAP_W-1:0] idx);
        logic [CHAR_W-1:0] sym;
        if (idx == '0)
            sym = ASCII_ZERO + CHAR_W'(key);
        else
            sym = first_letter(key) + CHAR_W'(idx - TAP_W'(1));
        return sym;
    endfunction

    function automatic logic [CHAR_W-1:0] single_symbol(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] sym;
        case (key)
            KEY_0:    sym = ASCII_ZERO;
            KEY_1:    sym = ASCII_ONE;
            KEY_STAR: sym = ASCII_STAR;
            KEY_HASH: sym = ASCII_HASH;
            default:  sym = ASCII_QUESTION;
        endcase
        return sym;
    endfunction

endpackage

`default_nettype wire

// ===== design/mtk_key_if.sv =====
// Input channel of the keypad block: key presses and time ticks.
// Depends on mtk_pkg for field widths.
`default_nettype none

interface mtk_key_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [mtk_pkg::KEY_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

// ===== design/mtk_char_if.sv =====
// Output channel of the keypad block: previewed and committed characters.
// Depends on mtk_pkg for field widths.
`default_nettype none

interface mtk_char_if;
    logic                       valid;
    logic                       ready;
    logic [mtk_pkg::CHAR_W-1:0] character;
    logic                       committed;

    modport source (output valid, output character, output committed, input ready);
    modport sink   (input valid, input character, input committed, output ready);
endinterface

`default_nettype wire

// ===== design/mtk_cfg_if.sv =====
// Configuration write channel of the keypad block.
// Depends on mtk_pkg for index and data widths.
`default_nettype none

interface mtk_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mtk_pkg::CFG_IDX_W-1:0]  index;
    logic [mtk_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/mtk_decode.sv =====
// Key press decoder: next tap position and the symbol it selects.
// Depends on mtk_pkg for the keypad tables and the press_t result type.
`default_nettype none

module mtk_decode (
    input  wire logic [mtk_pkg::KEY_W-1:0] key,
    input  wire logic                      repeat_press,
    input  wire logic [mtk_pkg::TAP_W-1:0] tap_index,
    output mtk_pkg::press_t                result
);

    logic [mtk_pkg::TAP_W-1:0] tap_inc;
    logic [mtk_pkg::TAP_W-1:0] tap_new;

    always_comb
    begin
        tap_inc = tap_index + mtk_pkg::TAP_W'(1);
        tap_new = '0;
        result  = '0;
        if (mtk_pkg::is_tap_key(key))
        begin
            // A repeat press walks round the key's symbols; anything else starts over.
            if (repeat_press && (tap_inc < mtk_pkg::tap_count(key)))
                tap_new = tap_inc;
            result.tap_index = tap_new;
            result.character = mtk_pkg::tap_symbol(key, tap_new);
        end
        else
        begin
            result.tap_index = '0;
            result.character = mtk_pkg::single_symbol(key);
        end
    end

endmodule

`default_nettype wire

// ===== design/multitap_keypad_text_entry.sv =====
// Multi-tap keypad text entry: one request per cycle, sustained while the output is taken.
// A request is held in the input register, and its result is loaded into the result
// register when the update stage advances, from which it can be taken.
// Throughput is set by the single update stage between the two registers.
// Reset (rst_n low, asynchronous) clears the key history and pending character,
// saturates the idle counter and loads both timing registers with 600.
`default_nettype none

module multitap_keypad_text_entry #(
    parameter int TICK_COUNTER_WIDTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mtk_key_if.sink     key_in,
    mtk_char_if.source  char_out,
    mtk_cfg_if.sink     cfg
);

    localparam int CMP_W = (TICK_COUNTER_WIDTH > mtk_pkg::CFG_DATA_W) ?
                           TICK_COUNTER_WIDTH : mtk_pkg::CFG_DATA_W;

    // Input register.
    logic                       in_valid_reg, in_valid_next;
    logic                       in_op_reg, in_op_next;
    logic [mtk_pkg::KEY_W-1:0]  in_key_reg, in_key_next;

    // Block state.
    logic [TICK_COUNTER_WIDTH-1:0] idle_reg, idle_next;
    logic [mtk_pkg::KEY_W-1:0]     last_key_reg, last_key_next;
    logic                          last_valid_reg, last_valid_next;
    logic [mtk_pkg::TAP_W-1:0]     tap_reg, tap_next;
    logic [mtk_pkg::CHAR_W-1:0]    pend_char_reg, pend_char_next;
    logic                          pend_valid_reg, pend_valid_next;

    logic [mtk_pkg::CFG_DATA_W-1:0] timeout_reg, timeout_next;
    logic [mtk_pkg::CFG_DATA_W-1:0] delay_reg, delay_next;

    // Result register.
    logic                       out_valid_reg, out_valid_next;
    logic [mtk_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic                       out_commit_reg, out_commit_next;

    logic                          advance;
    logic                          repeat_press;
    logic [TICK_COUNTER_WIDTH-1:0] idle_inc;
    mtk_pkg::press_t               press;

    assign advance = in_valid_reg && (!out_valid_reg || char_out.ready);
    assign key_in.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign char_out.valid     = out_valid_reg;
    assign char_out.character = out_char_reg;
    assign char_out.committed = out_commit_reg;

    assign repeat_press = last_valid_reg && (last_key_reg == in_key_reg) &&
                          (CMP_W'(idle_reg) <= CMP_W'(timeout_reg));
    assign idle_inc = (&idle_reg) ? idle_reg : idle_reg + TICK_COUNTER_WIDTH'(1);

    mtk_decode u_decode (
        .key          (in_key_reg),
        .repeat_press (repeat_press),
        .tap_index    (tap_reg),
        .result       (press)
    );

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_op_next      = in_op_reg;
        in_key_next     = in_key_reg;
        idle_next       = idle_reg;
        last_key_next   = last_key_reg;
        last_valid_next = last_valid_reg;
        tap_next        = tap_reg;
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        timeout_next    = timeout_reg;
        delay_next      = delay_reg;
        out_valid_next  = out_valid_reg;
        out_char_next   = out_char_reg;
        out_commit_next = out_commit_reg;

        if (key_in.valid && key_in.ready)
        begin
            in_valid_next = 1'b1;
            in_op_next    = key_in.operation;
            in_key_next   = key_in.key;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        if (char_out.ready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            if (in_op_reg == mtk_pkg::OP_PRESS)
            begin
                idle_next       = '0;
                last_key_next   = in_key_reg;
                last_valid_next = 1'b1;
                tap_next        = press.tap_index;
                pend_char_next  = press.character;
                pend_valid_next = 1'b1;
                out_valid_next  = 1'b1;
                out_char_next   = press.character;
                out_commit_next = 1'b0;
            end
            else
            begin
                idle_next = idle_inc;
                if (pend_valid_reg && (CMP_W'(idle_inc) > CMP_W'(delay_reg)))
                begin
                    pend_valid_next = 1'b0;
                    out_valid_next  = 1'b1;
                    out_char_next   = pend_char_reg;
                    out_commit_next = 1'b1;
                end
            end
        end

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mtk_pkg::CFG_CYCLE_TIMEOUT: timeout_next = cfg.data;
                mtk_pkg::CFG_COMMIT_DELAY:  delay_next   = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            idle_reg       <= '1;
            last_key_reg   <= '0;
            last_valid_reg <= 1'b0;
            tap_reg        <= '0;
            pend_valid_reg <= 1'b0;
            timeout_reg    <= mtk_pkg::CYCLE_TIMEOUT_RESET;
            delay_reg      <= mtk_pkg::COMMIT_DELAY_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            idle_reg       <= idle_next;
            last_key_reg   <= last_key_next;
            last_valid_reg <= last_valid_next;
            tap_reg        <= tap_next;
            pend_valid_reg <= pend_valid_next;
            timeout_reg    <= timeout_next;
            delay_reg      <= delay_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_op_reg      <= in_op_next;
        in_key_reg     <= in_key_next;
        pend_char_reg  <= pend_char_next;
        out_char_reg   <= out_char_next;
        out_commit_reg <= out_commit_next;
    end

endmodule

`default_nettype wire

// ===== design/mtk_checker.sv =====
// Port-level checks for the multi-tap keypad block, bound to its top level.
// Depends on mtk_pkg for field widths and on the top level's channel ports.
`default_nettype none

module mtk_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [mtk_pkg::CHAR_W-1:0] out_character,
    input wire logic                       out_committed
);

    // An undelivered result must hold until it is taken.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_character) && $stable(out_committed);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // With the result register empty the update stage always moves on.
    property p_ready_when_empty;
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready;
    endproperty
    a_ready_when_empty: assert property (p_ready_when_empty)
        else $error("input stalled with empty result register");

    // A preview is always a printable keypad symbol.
    property p_preview_printable;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_committed |-> out_character >= mtk_pkg::ASCII_HASH;
    endproperty
    a_preview_printable: assert property (p_preview_printable)
        else $error("preview character out of keypad range");

    // A committed character comes only from an earlier press, never from reset state.
    property p_commit_nonzero;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_committed |-> out_character != '0;
    endproperty
    a_commit_nonzero: assert property (p_commit_nonzero)
        else $error("committed character with no press behind it");

endmodule

bind multitap_keypad_text_entry mtk_checker u_mtk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (key_in.ready),
    .out_valid     (char_out.valid),
    .out_ready     (char_out.ready),
    .out_character (char_out.character),
    .out_committed (char_out.committed)
);

`default_nettype wire
